// ----- hw/rtl/tbp_pkg.sv -----
package tbp_pkg;

  localparam int unsigned PHT_ENTRIES     = 256;
  localparam int unsigned CHOOSER_ENTRIES = 256;
  localparam int unsigned BTB_ENTRIES     = 64;
  localparam int unsigned STACK_ENTRIES   = 16;
  localparam int unsigned HISTORY_BITS    = 8;

  localparam int unsigned PHT_AW  = $clog2(PHT_ENTRIES);
  localparam int unsigned CHO_AW  = $clog2(CHOOSER_ENTRIES);
  localparam int unsigned BTB_AW  = $clog2(BTB_ENTRIES);
  localparam int unsigned STK_AW  = (STACK_ENTRIES > 1) ? $clog2(STACK_ENTRIES) : 1;
  localparam int unsigned DEPTH_W = $clog2(STACK_ENTRIES + 1);

  // clearing pass after reset covers the larger counter table
  localparam int unsigned CLR_ENTRIES = (PHT_ENTRIES > CHOOSER_ENTRIES) ?
                                        PHT_ENTRIES : CHOOSER_ENTRIES;
  localparam int unsigned CLR_AW      = $clog2(CLR_ENTRIES);

  typedef enum logic [1:0] {
    OP_FETCH   = 2'd0,
    OP_RESOLVE = 2'd1,
    OP_RECOVER = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;

  // weakly not taken
  localparam logic [1:0] CTR_INIT = 2'd1;

  typedef struct packed {
    op_e         operation;
    logic [31:0] pc;
    logic [31:0] instruction;
    logic        outcome_taken;
    logic [31:0] outcome_target;
    logic [7:0]  saved_history;
    logic [4:0]  saved_depth;
  } tbp_in_t;

  typedef struct packed {
    logic        predict_taken;
    logic [31:0] predict_pc;
    logic [31:0] return_address;
    logic [4:0]  ckpt_depth;
    logic [7:0]  ckpt_history;
  } tbp_out_t;

  // return stack update request, one per committed beat
  typedef struct packed {
    logic        push;
    logic        pop;
    logic        restore;
    logic [31:0] push_data;
    logic [4:0]  restore_depth;
  } ras_ctl_t;

endpackage

// ----- hw/rtl/tbp_ram.sv -----
module tbp_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_q;
  logic [WIDTH-1:0] fwd_data_q;
  logic             fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  // write-first: same-edge write to the read address wins
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      fwd_q      <= wr_en_i && (wr_addr_i == rd_addr_i);
      fwd_data_q <= wr_data_i;
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_q;

endmodule

// ----- hw/rtl/tbp_ras.sv -----
module tbp_ras (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tbp_pkg::ras_ctl_t           ctl_i,
  output logic [31:0]                 ra_o,
  output logic [tbp_pkg::DEPTH_W-1:0] depth_o
);
  import tbp_pkg::*;

  logic [31:0]        stack_q [STACK_ENTRIES];
  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic [DEPTH_W-1:0] depth_m1;
  logic [DEPTH_W-1:0] rst_depth;
  logic               full, empty;

  assign full     = depth_q >= DEPTH_W'(STACK_ENTRIES);
  assign empty    = depth_q == '0;
  assign depth_m1 = depth_q - 1'b1;

  // recover depth saturates at capacity
  assign rst_depth = (9'(ctl_i.restore_depth) > 9'(STACK_ENTRIES)) ?
                     DEPTH_W'(STACK_ENTRIES) : DEPTH_W'(ctl_i.restore_depth);

  always_comb begin
    depth_d = depth_q;
    priority if (ctl_i.push) begin
      if (!full) depth_d = depth_q + 1'b1;
    end else if (ctl_i.pop) begin
      if (!empty) depth_d = depth_m1;
    end else if (ctl_i.restore) begin
      depth_d = rst_depth;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
    end else begin
      depth_q <= depth_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.push && !full) begin
      stack_q[depth_q[STK_AW-1:0]] <= ctl_i.push_data;
    end
  end

  assign ra_o    = empty ? 32'd0 : stack_q[depth_m1[STK_AW-1:0]];
  assign depth_o = depth_q;

endmodule

// ----- hw/rtl/tournament_branch_predictor.sv -----
// Channel   Dir  Handshake              Payload
// --------  ---  ---------------------  -------------------------
// in        in   in_valid_i/in_ready_o  in_data_i  (tbp_in_t)
// out       out  out_valid_o/out_ready_i out_data_o (tbp_out_t)
//
// One beat per clock sustained while results are taken; each beat passes the input register,
// then the result register. Table reads are launched at the input beat from synchronous
// RAMs; all state commits as the beat leaves the input stage.
// Reset: BTB valid bits, stack depth and history clear at once; the counter tables
// are rewritten to weakly-not-taken by a clearing pass over CLR_ENTRIES (256) entries,
// one entry per cycle, with in_ready_o held low until it ends.
// Stalls: a held result blocks the input stage only when that stage is also full.
module tournament_branch_predictor (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tbp_pkg::tbp_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tbp_pkg::tbp_out_t out_data_o
);
  import tbp_pkg::*;

  function automatic logic [PHT_AW-1:0] pht_idx(input logic [31:0] pc,
                                                input logic [HISTORY_BITS-1:0] h);
    logic [29:0] w;
    w = pc[31:2] ^ 30'(h);
    return w[PHT_AW-1:0];
  endfunction

  function automatic logic [CHO_AW-1:0] cho_idx(input logic [31:0] pc,
                                                input logic [HISTORY_BITS-1:0] h);
    logic [29:0] w;
    w = pc[31:2] ^ 30'(h);
    return w[CHO_AW-1:0];
  endfunction

  function automatic logic [HISTORY_BITS-1:0] snap_hist(input logic [7:0] s);
    logic [15:0] t;
    t = 16'(s);
    return t[HISTORY_BITS-1:0];
  endfunction

  function automatic logic [1:0] sat_move(input logic [1:0] c, input logic up);
    logic [1:0] r;
    r = c;
    if (up) begin
      if (c != 2'd3) r = c + 2'd1;
    end else begin
      if (c != 2'd0) r = c - 2'd1;
    end
    return r;
  endfunction

  // ---------------- clearing pass ----------------
  logic              clr_busy_q;
  logic [CLR_AW-1:0] clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_q      <= '0;
    end else if (clr_busy_q) begin
      clr_q <= clr_q + 1'b1;
      if (clr_q == CLR_AW'(CLR_ENTRIES - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // ---------------- handshake / stage control ----------------
  logic     s1_vld_q;
  tbp_in_t  s1_q;
  logic     out_vld_q;
  tbp_out_t out_q, out_d;
  logic     s1_adv, in_acc;

  assign s1_adv     = s1_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !clr_busy_q && (!s1_vld_q || s1_adv);
  assign in_acc     = in_valid_i && in_ready_o;

  // ---------------- global history ----------------
  logic [HISTORY_BITS-1:0] hist_q, hist_d, hist_upd;

  // history seen by the incoming beat includes the beat now committing
  assign hist_d = s1_adv ? hist_upd : hist_q;

  // ---------------- read side (incoming beat) ----------------
  logic [HISTORY_BITS-1:0] in_hist;
  logic [PHT_AW-1:0]       l_ra, g_ra;
  logic [CHO_AW-1:0]       c_ra;
  logic [BTB_AW-1:0]       b_ra;

  assign in_hist = (in_data_i.operation == OP_RESOLVE) ?
                   snap_hist(in_data_i.saved_history) : hist_d;
  assign l_ra = in_data_i.pc[PHT_AW+1:2];
  assign g_ra = pht_idx(in_data_i.pc, in_hist);
  assign c_ra = cho_idx(in_data_i.pc, in_hist);
  assign b_ra = in_data_i.pc[BTB_AW+1:2];

  // ---------------- write side (committing resolve) ----------------
  logic [HISTORY_BITS-1:0] s1_shist;
  logic [PHT_AW-1:0]       l_wa, g_wa;
  logic [CHO_AW-1:0]       c_wa;
  logic [BTB_AW-1:0]       b_wa;
  logic                    res_we, btb_we;
  logic [1:0]              lcl_wd, glb_wd, cho_wd;

  assign s1_shist = snap_hist(s1_q.saved_history);
  assign l_wa     = s1_q.pc[PHT_AW+1:2];
  assign g_wa     = pht_idx(s1_q.pc, s1_shist);
  assign c_wa     = cho_idx(s1_q.pc, s1_shist);
  assign b_wa     = s1_q.pc[BTB_AW+1:2];
  assign res_we   = s1_adv && (s1_q.operation == OP_RESOLVE);
  assign btb_we   = res_we && s1_q.outcome_taken;

  // counter write ports: clearing pass first, then training
  logic              ctr_we;
  logic [PHT_AW-1:0] l_wa_m, g_wa_m;
  logic [CHO_AW-1:0] c_wa_m;
  logic [1:0]        lcl_wm, glb_wm, cho_wm;

  assign ctr_we = clr_busy_q || res_we;
  assign l_wa_m = clr_busy_q ? clr_q[PHT_AW-1:0] : l_wa;
  assign g_wa_m = clr_busy_q ? clr_q[PHT_AW-1:0] : g_wa;
  assign c_wa_m = clr_busy_q ? clr_q[CHO_AW-1:0] : c_wa;
  assign lcl_wm = clr_busy_q ? CTR_INIT : lcl_wd;
  assign glb_wm = clr_busy_q ? CTR_INIT : glb_wd;
  assign cho_wm = clr_busy_q ? CTR_INIT : cho_wd;

  // ---------------- tables ----------------
  logic [1:0]  lcl_rd, glb_rd, cho_rd;
  logic [63:0] btb_rd;

  tbp_ram #(.WIDTH(2), .DEPTH(PHT_ENTRIES)) u_lcl (
    .clk_i, .rd_en_i(in_acc), .rd_addr_i(l_ra),
    .wr_en_i(ctr_we), .wr_addr_i(l_wa_m), .wr_data_i(lcl_wm), .rd_data_o(lcl_rd)
  );

  tbp_ram #(.WIDTH(2), .DEPTH(PHT_ENTRIES)) u_glb (
    .clk_i, .rd_en_i(in_acc), .rd_addr_i(g_ra),
    .wr_en_i(ctr_we), .wr_addr_i(g_wa_m), .wr_data_i(glb_wm), .rd_data_o(glb_rd)
  );

  tbp_ram #(.WIDTH(2), .DEPTH(CHOOSER_ENTRIES)) u_cho (
    .clk_i, .rd_en_i(in_acc), .rd_addr_i(c_ra),
    .wr_en_i(ctr_we), .wr_addr_i(c_wa_m), .wr_data_i(cho_wm), .rd_data_o(cho_rd)
  );

  // tag in the upper half, target in the lower
  tbp_ram #(.WIDTH(64), .DEPTH(BTB_ENTRIES)) u_btb (
    .clk_i, .rd_en_i(in_acc), .rd_addr_i(b_ra),
    .wr_en_i(btb_we), .wr_addr_i(b_wa), .wr_data_i({s1_q.pc, s1_q.outcome_target}),
    .rd_data_o(btb_rd)
  );

  // BTB valid bits; the read copy follows the table read, same-edge write wins
  logic [BTB_ENTRIES-1:0] btb_vld_q;
  logic                   btb_vrd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      btb_vld_q <= '0;
      btb_vrd_q <= 1'b0;
    end else begin
      if (in_acc) begin
        btb_vrd_q <= btb_vld_q[b_ra] || (btb_we && (b_wa == b_ra));
      end
      if (btb_we) begin
        btb_vld_q[b_wa] <= 1'b1;
      end
    end
  end

  logic [1:0] lcl_ctr, glb_ctr, cho_ctr;
  logic       btb_hit;

  assign lcl_ctr = lcl_rd;
  assign glb_ctr = glb_rd;
  assign cho_ctr = cho_rd;
  assign btb_hit = btb_vrd_q && (btb_rd[63:32] == s1_q.pc);

  // ---------------- training ----------------
  logic pl, pg;

  assign pl     = lcl_ctr[1];
  assign pg     = glb_ctr[1];
  assign lcl_wd = sat_move(lcl_ctr, s1_q.outcome_taken);
  assign glb_wd = sat_move(glb_ctr, s1_q.outcome_taken);

  always_comb begin
    cho_wd = cho_ctr;
    priority if (pg && !pl) begin
      cho_wd = sat_move(cho_ctr, 1'b1);
    end else if (pl && !pg) begin
      cho_wd = sat_move(cho_ctr, 1'b0);
    end
  end

  // ---------------- fetch: predict and decode ----------------
  logic        is_fetch, dir, tk;
  logic [31:0] pc4;
  logic [6:0]  opcode;
  logic [4:0]  rd, rs1;
  logic [11:0] imm;
  logic        is_link, is_ret;

  assign is_fetch = s1_q.operation == OP_FETCH;
  assign dir      = cho_ctr[1] ? glb_ctr[1] : lcl_ctr[1];
  assign tk       = is_fetch && btb_hit && dir;
  assign pc4      = s1_q.pc + 32'd4;
  assign opcode   = s1_q.instruction[6:0];
  assign rd       = s1_q.instruction[11:7];
  assign rs1      = s1_q.instruction[19:15];
  assign imm      = s1_q.instruction[31:20];
  assign is_link  = (opcode == OPC_JAL) && ((rd == 5'd1) || (rd == 5'd5));
  assign is_ret   = (opcode == OPC_JALR) && (rd == 5'd0) &&
                    ((rs1 == 5'd1) || (rs1 == 5'd5)) && (imm == 12'd0);

  always_comb begin
    priority if (s1_q.operation == OP_RECOVER) begin
      hist_upd = s1_shist;
    end else if (is_fetch && (opcode == OPC_BRANCH)) begin
      hist_upd = HISTORY_BITS'({hist_q, tk});
    end else if (is_fetch && ((opcode == OPC_JAL) || (opcode == OPC_JALR))) begin
      hist_upd = HISTORY_BITS'({hist_q, 1'b1});
    end else begin
      hist_upd = hist_q;
    end
  end

  // ---------------- return stack ----------------
  ras_ctl_t           ras_ctl;
  logic [31:0]        ras_ra;
  logic [DEPTH_W-1:0] ras_depth;

  always_comb begin
    ras_ctl.push          = s1_adv && is_fetch && is_link;
    ras_ctl.pop           = s1_adv && is_fetch && is_ret;
    ras_ctl.restore       = s1_adv && (s1_q.operation == OP_RECOVER);
    ras_ctl.push_data     = pc4;
    ras_ctl.restore_depth = s1_q.saved_depth;
  end

  tbp_ras u_ras (
    .clk_i, .rst_ni, .ctl_i(ras_ctl), .ra_o(ras_ra), .depth_o(ras_depth)
  );

  // ---------------- result ----------------
  logic [15:0] depth_x, hist_x;

  assign depth_x = 16'(ras_depth);
  assign hist_x  = 16'(hist_q);

  always_comb begin
    out_d.predict_taken  = tk;
    out_d.predict_pc     = is_fetch ? (tk ? btb_rd[31:0] : pc4) : 32'd0;
    out_d.return_address = ras_ra;
    out_d.ckpt_depth     = depth_x[4:0];
    out_d.ckpt_history   = hist_x[7:0];
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      hist_q    <= '0;
    end else begin
      hist_q <= hist_d;
      if (in_ready_o) begin
        s1_vld_q <= in_valid_i;
      end
      if (s1_adv) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= in_data_i;
    end
    if (s1_adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ras_depth <= DEPTH_W'(STACK_ENTRIES))
    else $error("return stack depth above capacity");

  a_hold_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_adv |=> $stable(hist_q) && $stable(ras_depth))
    else $error("state changed without a committing beat");

  a_clear_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !in_ready_o)
    else $error("input accepted during the clearing pass");
`endif

endmodule
